// ----- sv/qmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qmm_pkg
// types and constants for the quad motor mixer
// ----------------------------------------------------------------------------
`default_nettype none

package qmm_pkg;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_ROTOR_SPEED_MAX = 2'd0,
    REG_PWM_MIN_US      = 2'd1,
    REG_PWM_MAX_US      = 2'd2
  } reg_index_t;

  localparam int unsigned CfgW      = 12;
  localparam int unsigned AddrW     = 4;

  // squared speed numerators over the common denominator
  localparam int unsigned ThrustNum = 500000;
  localparam int unsigned TorqueNum = 2500000;
  localparam int unsigned CommonDen = 41;

  // 250 rad/s in q.8
  localparam int unsigned RootOffset = 64000;

  localparam logic [CfgW-1:0] RstSpeedMax = 12'd1000;
  localparam logic [CfgW-1:0] RstPwmMin   = 12'd1000;
  localparam logic [CfgW-1:0] RstPwmMax   = 12'd2000;

  // root bits and quotient bits
  localparam int unsigned RootW = 19;
  localparam int unsigned QuoW  = 12;

endpackage

`default_nettype wire

// ----- sv/quad_motor_mixer.sv -----
// ----------------------------------------------------------------------------
// quad_motor_mixer
// x-frame quadcopter mixer: thrust and roll/pitch torque to four pwm widths
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one word per command, thrust q8.16, roll and pitch q5.16
//   m_* stream: one word per command with four 12-bit pulse widths in us
//   apb port: rotor_speed_max at 0x0, pwm_min_us at 0x4, pwm_max_us at 0x8,
//     write only while no command is in flight
// timing
//   38-stage pipeline: the last stage registers the word on m_tdata
//   one word per cycle while not stalled by m_tready; the depth is set by the 19 root steps
//   (one root bit per stage) and the 12 divide steps (one quotient bit
//   per stage) that follow the mixing multipliers
// reset
//   rst clears every stage valid and loads the register defaults
//   (1000 rad/s, 1000 us, 2000 us)
// stall
//   when m_tready is low with a word waiting, the whole pipe holds and
//   s_tready drops; no word is lost or repeated, bubbles are kept
// ----------------------------------------------------------------------------
`default_nettype none

module quad_motor_mixer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // thrust[23:0], roll_torque[44:24], pitch_torque[65:45], zero pad
  input  wire logic [71:0]               s_tdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // pwm_motor0[11:0], pwm_motor1[23:12], pwm_motor2[35:24], pwm_motor3[47:36]
  output logic [47:0]                    m_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [qmm_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import qmm_pkg::*;

  localparam int unsigned NumStages = 38;

  // configuration registers
  logic [CfgW-1:0] rotor_speed_max;
  logic [CfgW-1:0] pwm_min_us;
  logic [CfgW-1:0] pwm_max_us;
  reg_index_t      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor_speed_max <= RstSpeedMax;
      pwm_min_us      <= RstPwmMin;
      pwm_max_us      <= RstPwmMax;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_ROTOR_SPEED_MAX: rotor_speed_max <= pwdata[CfgW-1:0];
        REG_PWM_MIN_US:      pwm_min_us      <= pwdata[CfgW-1:0];
        REG_PWM_MAX_US:      pwm_max_us      <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROTOR_SPEED_MAX: prdata = {20'd0, rotor_speed_max};
      REG_PWM_MIN_US:      prdata = {20'd0, pwm_min_us};
      REG_PWM_MAX_US:      prdata = {20'd0, pwm_max_us};
      default:             prdata = 32'd0;
    endcase
  end

  // zero span counts as one; den is span in q.8
  logic [CfgW-1:0] span_eff;
  logic [19:0]     den;
  assign span_eff = (rotor_speed_max == '0) ? 12'd1 : rotor_speed_max;
  assign den      = {span_eff, 8'd0};

  // pipeline control: everything moves together unless the output word is stuck
  logic                 advance;
  logic [NumStages-1:0] vld;

  assign advance  = !vld[NumStages-1] || m_tready;
  assign s_tready = advance;
  assign m_tvalid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NumStages-2:0], s_tvalid};
    end
  end

  // stage 0: input word
  logic signed [23:0] thrust;
  logic signed [20:0] roll_torque;
  logic signed [20:0] pitch_torque;

  always_ff @(posedge clk) begin
    if (advance) begin
      thrust       <= s_tdata[23:0];
      roll_torque  <= s_tdata[44:24];
      pitch_torque <= s_tdata[65:45];
    end
  end

  // stage 1: thrust and torque products (d = p - r, e = p + r)
  logic signed [21:0] tq_diff;
  logic signed [21:0] tq_sum;
  logic signed [45:0] t_prod;
  logic signed [45:0] d_prod;
  logic signed [45:0] e_prod;

  assign tq_diff = 22'(pitch_torque) - 22'(roll_torque);
  assign tq_sum  = 22'(pitch_torque) + 22'(roll_torque);

  always_ff @(posedge clk) begin
    if (advance) begin
      t_prod <= 46'(thrust)  * 46'(signed'(ThrustNum));
      d_prod <= 46'(tq_diff) * 46'(signed'(TorqueNum));
      e_prod <= 46'(tq_sum)  * 46'(signed'(TorqueNum));
    end
  end

  // per motor numerators: m0 t+d, m1 t-d, m2 t-e, m3 t+e
  logic signed [45:0] mix_n [4];
  assign mix_n[0] = t_prod + d_prod;
  assign mix_n[1] = t_prod - d_prod;
  assign mix_n[2] = t_prod - e_prod;
  assign mix_n[3] = t_prod + e_prod;

  logic [11:0] pwm_out [4];

  genvar m, j;
  generate
    for (m = 0; m < 4; m++) begin : g_motor
      // root search: largest q with 41*q*q <= n, one bit per stage
      logic [43:0]      sq_rem [RootW+1];
      logic [RootW-1:0] sq_q   [RootW+1];
      logic [24:0]      sq_q41 [RootW+1];

      // stage 2: negative sums clip to zero
      always_ff @(posedge clk) begin
        if (advance) begin
          sq_rem[0] <= mix_n[m][45] ? 44'd0 : mix_n[m][43:0];
          sq_q[0]   <= '0;
          sq_q41[0] <= '0;
        end
      end

      for (j = 0; j < RootW; j++) begin : g_root
        localparam int unsigned Bit = RootW - 1 - j;
        logic [45:0] delta;
        logic        take;

        // 41*((q+2^b)^2 - q^2) = (41q << (b+1)) + (41 << 2b)
        assign delta = (46'(sq_q41[j]) << (Bit + 1)) + (46'(CommonDen) << (2 * Bit));
        assign take  = {2'b00, sq_rem[j]} >= delta;

        always_ff @(posedge clk) begin
          if (advance) begin
            sq_rem[j+1] <= take ? sq_rem[j] - delta[43:0] : sq_rem[j];
            sq_q[j+1]   <= take ? sq_q[j] | RootW'(1 << Bit) : sq_q[j];
            sq_q41[j+1] <= take ? sq_q41[j] + 25'(CommonDen << Bit) : sq_q41[j];
          end
        end
      end

      // map stage 1: (q - offset) * (hi - lo) and lo * span
      logic signed [20:0] q_off;
      logic signed [12:0] pwm_span;
      logic signed [33:0] map_x;
      logic [23:0]        map_ls;

      assign q_off    = signed'({2'b00, sq_q[RootW]}) - 21'(RootOffset);
      assign pwm_span = signed'({1'b0, pwm_max_us}) - signed'({1'b0, pwm_min_us});

      always_ff @(posedge clk) begin
        if (advance) begin
          map_x  <= 34'(q_off) * 34'(pwm_span);
          map_ls <= pwm_min_us * span_eff;
        end
      end

      // map stage 2: numerator sign and magnitude
      logic signed [33:0] map_num;
      logic               num_neg;
      logic [33:0]        num_mag;

      assign map_num = map_x + signed'({2'b00, map_ls, 8'd0});

      always_ff @(posedge clk) begin
        if (advance) begin
          num_neg <= map_num[33];
          num_mag <= map_num[33] ? 34'(-map_num) : 34'(map_num);
        end
      end

      // divide: saturate at 4096, then 12 restoring steps
      logic [33:0]     dv_rem [QuoW+1];
      logic [QuoW-1:0] dv_quo [QuoW+1];
      logic            dv_neg [QuoW+1];
      logic            dv_sat [QuoW+1];

      always_ff @(posedge clk) begin
        if (advance) begin
          dv_rem[0] <= num_mag;
          dv_quo[0] <= '0;
          dv_neg[0] <= num_neg;
          dv_sat[0] <= num_mag >= {2'b00, den, 12'd0};
        end
      end

      for (j = 0; j < QuoW; j++) begin : g_div
        localparam int unsigned Bit = QuoW - 1 - j;
        logic [33:0] dshift;
        logic        take;

        assign dshift = 34'(den) << Bit;
        assign take   = !dv_sat[j] && (dv_rem[j] >= dshift);

        always_ff @(posedge clk) begin
          if (advance) begin
            dv_rem[j+1] <= take ? dv_rem[j] - dshift : dv_rem[j];
            dv_quo[j+1] <= take ? dv_quo[j] | QuoW'(1 << Bit) : dv_quo[j];
            dv_neg[j+1] <= dv_neg[j];
            dv_sat[j+1] <= dv_sat[j];
          end
        end
      end

      // clamp: floor test first, negative quotient always under the floor
      logic [12:0] mag;
      logic [11:0] clamped;

      assign mag = dv_sat[QuoW] ? 13'd4096 : {1'b0, dv_quo[QuoW]};

      always_comb begin
        priority if (dv_neg[QuoW] && mag != '0) begin
          clamped = pwm_min_us;
        end else if (mag < {1'b0, pwm_min_us}) begin
          clamped = pwm_min_us;
        end else if (mag > {1'b0, pwm_max_us}) begin
          clamped = pwm_max_us;
        end else begin
          clamped = mag[11:0];
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          pwm_out[m] <= clamped;
        end
      end
    end
  endgenerate

  assign m_tdata = {pwm_out[3], pwm_out[2], pwm_out[1], pwm_out[0]};

endmodule

`default_nettype wire
